// ----- sv/tfps_pkg.sv -----
// Shared constants and item types for the textured floor pixel sampler.
package tfps_pkg;

   localparam int HALF_HEIGHT   = 120;
   localparam int TEX_WIDTH     = 64;
   localparam int TEX_HEIGHT    = 64;
   localparam int TEXTURE_COUNT = 3;

   localparam int TEX_SIZE   = TEX_WIDTH * TEX_HEIGHT;
   localparam int STORE_SIZE = TEXTURE_COUNT * TEX_SIZE;
   localparam int ADDR_W     = $clog2(STORE_SIZE);

   // row distance 100/(row+1) in unsigned Q7.16
   localparam int DIST_NUM  = 100 * 65536;
   localparam int DIST_W    = 23;
   localparam int SHADE_W   = 3;
   localparam int MAX_SHADE = 7;

   // item op codes
   localparam logic OP_LOAD_TEXEL   = 1'b0;
   localparam logic OP_RENDER_PIXEL = 1'b1;

   typedef enum logic [2:0] {
      CSR_POS_X          = 3'd0,
      CSR_POS_Y          = 3'd1,
      CSR_LEFT_DIR_X     = 3'd2,
      CSR_LEFT_DIR_Y     = 3'd3,
      CSR_COL_STEP_X     = 3'd4,
      CSR_COL_STEP_Y     = 3'd5,
      CSR_TEXTURE_SELECT = 3'd6,
      CSR_PALETTE_BASE   = 3'd7
   } csr_index_type;

   localparam logic [7:0] PALETTE_RESET = 8'd96;

   typedef struct packed {
      logic [23:0] pos_x;
      logic [23:0] pos_y;
      logic [15:0] left_dir_x;
      logic [15:0] left_dir_y;
      logic [17:0] col_step_x;
      logic [17:0] col_step_y;
      logic [1:0]  texture_select;
      logic [7:0]  palette_base;
   } cfg_type;

   typedef struct packed {
      logic               render;
      logic               draw;
      logic [SHADE_W-1:0] shade;
      logic [7:0]         screen_row;
      logic               wr_en;
      logic [ADDR_W-1:0]  addr;
      logic [7:0]         wr_data;
   } geom_item_type;

   typedef struct packed {
      logic               draw;
      logic [SHADE_W-1:0] shade;
      logic [7:0]         screen_row;
      logic [7:0]         texel;
   } texel_item_type;

endpackage

// ----- sv/tfps_geom.sv -----
// Floor projection pipeline: row distance, view direction, world position, texel address.
module tfps_geom
   import tfps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic          in_op,
   input  logic [6:0]    in_row,
   input  logic [8:0]    in_col,
   input  logic [7:0]    in_wall_foot,
   input  logic [1:0]    in_texture_number,
   input  logic [11:0]   in_texel_index,
   input  logic [7:0]    in_texel_value,
   output logic          out_valid,
   input  logic          out_ready,
   output geom_item_type out_item
);

   localparam int ROW_DEPTH = 128;
   localparam int SCR_W     = $clog2(ROW_DEPTH + HALF_HEIGHT);
   localparam int SHADE_LSB = 18;
   localparam int PROD_W    = 28;
   localparam int DIR_W     = 29;
   localparam int MUL_W     = 53;
   localparam int WORLD_W   = 54;
   localparam int SCALED_W  = 64;
   localparam int FRAC_W    = 40;
   localparam int TX_W      = $clog2(TEX_WIDTH);
   localparam int TY_W      = $clog2(TEX_HEIGHT);
   localparam int STAGES    = 5;

   typedef struct packed {
      logic               render;
      logic               draw;
      logic [SHADE_W-1:0] shade;
      logic [7:0]         screen_row;
      logic               wr_en;
      logic [ADDR_W-1:0]  load_addr;
      logic [7:0]         wr_data;
   } ctl_type;

   // trunc(world * size / 2^40) toward zero, masked to the texture
   function automatic logic [7:0] tex_coord(logic signed [WORLD_W-1:0] world,
                                            int unsigned size);
      logic [SCALED_W-1:0] scaled;
      logic                round_up;
      logic [7:0]          q;
      scaled = {{(SCALED_W-WORLD_W){world[WORLD_W-1]}}, world} * SCALED_W'(size);
      round_up = scaled[SCALED_W-1] && (scaled[FRAC_W-1:0] != '0);
      q = scaled[FRAC_W +: 8] + {7'b0, round_up};
      return q & 8'(size - 1);
   endfunction

   // distance rom, built at elaboration
   logic [DIST_W-1:0] dist_rom [ROW_DEPTH];
   for (genvar r = 0; r < ROW_DEPTH; r++) begin : g_dist
      localparam int Dist = (DIST_NUM + (r + 1) / 2) / (r + 1);
      assign dist_rom[r] = DIST_W'(Dist);
   end

   // stage flow control
   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   adv;

   always_comb begin
      adv[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // stage 0: rom, screen compare, column products, load address
   logic [DIST_W-1:0]        dist_in;
   logic [SCR_W-1:0]         screen_in;
   ctl_type                  ctl0_in;
   logic signed [PROD_W-1:0] prod_x_in;
   logic signed [PROD_W-1:0] prod_y_in;

   always_comb begin
      dist_in   = dist_rom[in_row];
      screen_in = SCR_W'(in_row) + SCR_W'(HALF_HEIGHT);
      ctl0_in.render     = (in_op == OP_RENDER_PIXEL);
      ctl0_in.draw       = 32'(screen_in) > 32'(in_wall_foot);
      ctl0_in.screen_row = screen_in[7:0];
      if (dist_in[DIST_W-1:SHADE_LSB] > MAX_SHADE) begin
         ctl0_in.shade = SHADE_W'(MAX_SHADE);
      end else begin
         ctl0_in.shade = dist_in[SHADE_LSB +: SHADE_W];
      end
      ctl0_in.wr_en = (in_op == OP_LOAD_TEXEL)
                      && (32'(in_texture_number) < 32'(TEXTURE_COUNT))
                      && (32'(in_texel_index) < 32'(TEX_SIZE));
      ctl0_in.load_addr = ADDR_W'(in_texture_number) * ADDR_W'(TEX_SIZE)
                          + ADDR_W'(in_texel_index);
      ctl0_in.wr_data = in_texel_value;
      prod_x_in = $signed({1'b0, in_col}) * $signed(cfg.col_step_x);
      prod_y_in = $signed({1'b0, in_col}) * $signed(cfg.col_step_y);
   end

   ctl_type                  ctl0_ff;
   logic [DIST_W-1:0]        dist0_ff;
   logic signed [PROD_W-1:0] prod_x0_ff;
   logic signed [PROD_W-1:0] prod_y0_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ctl0_ff    <= ctl0_in;
         dist0_ff   <= dist_in;
         prod_x0_ff <= prod_x_in;
         prod_y0_ff <= prod_y_in;
      end
   end

   // stage 1: dir = left_dir * 2^10 + col * step (2^-24 units)
   logic signed [DIR_W-1:0] ldir_x_ext;
   logic signed [DIR_W-1:0] ldir_y_ext;
   logic signed [DIR_W-1:0] prod_x_ext;
   logic signed [DIR_W-1:0] prod_y_ext;

   always_comb begin
      ldir_x_ext = {{(DIR_W-26){cfg.left_dir_x[15]}}, cfg.left_dir_x, 10'b0};
      ldir_y_ext = {{(DIR_W-26){cfg.left_dir_y[15]}}, cfg.left_dir_y, 10'b0};
      prod_x_ext = {{(DIR_W-PROD_W){prod_x0_ff[PROD_W-1]}}, prod_x0_ff};
      prod_y_ext = {{(DIR_W-PROD_W){prod_y0_ff[PROD_W-1]}}, prod_y0_ff};
   end

   ctl_type                 ctl1_ff;
   logic [DIST_W-1:0]       dist1_ff;
   logic signed [DIR_W-1:0] dir_x1_ff;
   logic signed [DIR_W-1:0] dir_y1_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         ctl1_ff   <= ctl0_ff;
         dist1_ff  <= dist0_ff;
         dir_x1_ff <= ldir_x_ext + prod_x_ext;
         dir_y1_ff <= ldir_y_ext + prod_y_ext;
      end
   end

   // stage 2: dist * dir (2^-40 units)
   ctl_type                 ctl2_ff;
   logic signed [MUL_W-1:0] mul_x2_ff;
   logic signed [MUL_W-1:0] mul_y2_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         ctl2_ff   <= ctl1_ff;
         mul_x2_ff <= $signed({1'b0, dist1_ff}) * dir_x1_ff;
         mul_y2_ff <= $signed({1'b0, dist1_ff}) * dir_y1_ff;
      end
   end

   // stage 3: world = pos * 2^24 + dist * dir
   logic signed [WORLD_W-1:0] pos_x_ext;
   logic signed [WORLD_W-1:0] pos_y_ext;
   logic signed [WORLD_W-1:0] mul_x_ext;
   logic signed [WORLD_W-1:0] mul_y_ext;

   always_comb begin
      pos_x_ext = {{(WORLD_W-48){cfg.pos_x[23]}}, cfg.pos_x, 24'b0};
      pos_y_ext = {{(WORLD_W-48){cfg.pos_y[23]}}, cfg.pos_y, 24'b0};
      mul_x_ext = {{(WORLD_W-MUL_W){mul_x2_ff[MUL_W-1]}}, mul_x2_ff};
      mul_y_ext = {{(WORLD_W-MUL_W){mul_y2_ff[MUL_W-1]}}, mul_y2_ff};
   end

   ctl_type                   ctl3_ff;
   logic signed [WORLD_W-1:0] world_x3_ff;
   logic signed [WORLD_W-1:0] world_y3_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         ctl3_ff     <= ctl2_ff;
         world_x3_ff <= pos_x_ext + mul_x_ext;
         world_y3_ff <= pos_y_ext + mul_y_ext;
      end
   end

   // stage 4: texture coordinates and store address
   logic [7:0]        tx8;
   logic [7:0]        ty8;
   logic [1:0]        sel;
   logic [ADDR_W-1:0] tex_addr;
   geom_item_type     item_in;

   always_comb begin
      tx8 = tex_coord(world_x3_ff, TEX_WIDTH);
      ty8 = tex_coord(world_y3_ff, TEX_HEIGHT);
      if (32'(cfg.texture_select) >= 32'(TEXTURE_COUNT)) begin
         sel = 2'(TEXTURE_COUNT - 1);
      end else begin
         sel = cfg.texture_select;
      end
      tex_addr = ADDR_W'(sel) * ADDR_W'(TEX_SIZE)
                 + ADDR_W'(ty8[TY_W-1:0]) * ADDR_W'(TEX_WIDTH)
                 + ADDR_W'(tx8[TX_W-1:0]);
      item_in.render     = ctl3_ff.render;
      item_in.draw       = ctl3_ff.draw;
      item_in.shade      = ctl3_ff.shade;
      item_in.screen_row = ctl3_ff.screen_row;
      item_in.wr_en      = ctl3_ff.wr_en;
      item_in.addr       = ctl3_ff.render ? tex_addr : ctl3_ff.load_addr;
      item_in.wr_data    = ctl3_ff.wr_data;
   end

   geom_item_type item4_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         item4_ff <= item_in;
      end
   end

   assign out_item = item4_ff;

endmodule

// ----- sv/tfps_store.sv -----
// Texture store: single-port byte memory, written by load items, read by render items.
module tfps_store
   import tfps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  geom_item_type  in_item,
   output logic           out_valid,
   input  logic           out_ready,
   output texel_item_type out_item
);

   logic [7:0]         mem [STORE_SIZE];
   logic [7:0]         rd_ff;
   logic               valid_ff;
   logic               draw_ff;
   logic [SHADE_W-1:0] shade_ff;
   logic [7:0]         screen_row_ff;

   assign in_ready = !valid_ff || out_ready;

   // loads and renders pass in order, so a render always sees earlier loads
   always_ff @(posedge clock) begin
      if (in_valid && in_ready && in_item.wr_en) begin
         mem[in_item.addr] <= in_item.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rd_ff         <= mem[in_item.addr];
         draw_ff       <= in_item.draw;
         shade_ff      <= in_item.shade;
         screen_row_ff <= in_item.screen_row;
      end
   end

   // load items end here
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid && in_item.render;
      end
   end

   assign out_valid           = valid_ff;
   assign out_item.draw       = draw_ff;
   assign out_item.shade      = shade_ff;
   assign out_item.screen_row = screen_row_ff;
   assign out_item.texel      = rd_ff;

endmodule

// ----- sv/tfps_shade.sv -----
// Distance shading, palette offset and result register.
module tfps_shade
   import tfps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     palette_base,
   input  logic           in_valid,
   output logic           in_ready,
   input  texel_item_type in_item,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [7:0]     out_pixel_value,
   output logic           out_draw,
   output logic [7:0]     out_screen_row
);

   logic       valid_ff;
   logic [7:0] pixel_ff;
   logic       draw_ff;
   logic [7:0] screen_row_ff;
   logic [7:0] shade_ext;
   logic [7:0] shaded;
   logic [7:0] pixel_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      shade_ext = {{(8-SHADE_W){1'b0}}, in_item.shade};
      shaded    = (in_item.texel > shade_ext) ? in_item.texel - shade_ext : 8'd0;
      pixel_in  = in_item.draw ? shaded + palette_base : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         pixel_ff      <= pixel_in;
         draw_ff       <= in_item.draw;
         screen_row_ff <= in_item.screen_row;
      end
   end

   assign out_valid       = valid_ff;
   assign out_pixel_value = pixel_ff;
   assign out_draw        = draw_ff;
   assign out_screen_row  = screen_row_ff;

endmodule

// ----- sv/textured_floor_pixel_sampler.sv -----
// Top level of the textured floor pixel sampler: registers, pipeline and checks.
//
// Takes one item per clock and sustains that rate unless rsp_ready stalls: a
// render item (op 1) gives one pixel on rsp_ after five projection stages, the
// texture store read and the shade/output register; a load item (op 0) writes
// one texel into the store and gives no result. All stages hand over through
// valid/ready, so a stall on rsp_ready backs up stage by stage and empty
// stages still take new items. The texture store is one single-port memory;
// a load and a render share its port in stream order, so a render sees every
// load taken before it. The store is not cleared after reset: read only
// texels that have been loaded. Pixels at or above the wall bottom come out
// with draw 0 and pixel_value 0. The user must write configuration through
// csr_ only while no item is in flight; the block does not enforce this.
module textured_floor_pixel_sampler
   import tfps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_write_data,
   // item input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [6:0]  req_row,
   input  logic [8:0]  req_col,
   input  logic [7:0]  req_wall_foot,
   input  logic [1:0]  req_texture_number,
   input  logic [11:0] req_texel_index,
   input  logic [7:0]  req_texel_value,
   // pixel result
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_value,
   output logic        rsp_draw,
   output logic [7:0]  rsp_screen_row
);

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{palette_base: PALETTE_RESET, default: '0};
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_POS_X:          cfg_ff.pos_x          <= csr_write_data;
            CSR_POS_Y:          cfg_ff.pos_y          <= csr_write_data;
            CSR_LEFT_DIR_X:     cfg_ff.left_dir_x     <= csr_write_data[15:0];
            CSR_LEFT_DIR_Y:     cfg_ff.left_dir_y     <= csr_write_data[15:0];
            CSR_COL_STEP_X:     cfg_ff.col_step_x     <= csr_write_data[17:0];
            CSR_COL_STEP_Y:     cfg_ff.col_step_y     <= csr_write_data[17:0];
            CSR_TEXTURE_SELECT: cfg_ff.texture_select <= csr_write_data[1:0];
            CSR_PALETTE_BASE:   cfg_ff.palette_base   <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // projection: item in, store address out
   logic          geom_valid;
   logic          geom_ready;
   geom_item_type geom_item;

   tfps_geom u_geom (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .in_valid          (req_valid),
      .in_ready          (req_ready),
      .in_op             (req_op),
      .in_row            (req_row),
      .in_col            (req_col),
      .in_wall_foot      (req_wall_foot),
      .in_texture_number (req_texture_number),
      .in_texel_index    (req_texel_index),
      .in_texel_value    (req_texel_value),
      .out_valid         (geom_valid),
      .out_ready         (geom_ready),
      .out_item          (geom_item)
   );

   // texture store: loads write, renders read
   logic           store_valid;
   logic           store_ready;
   texel_item_type store_item;

   tfps_store u_store (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (geom_valid),
      .in_ready  (geom_ready),
      .in_item   (geom_item),
      .out_valid (store_valid),
      .out_ready (store_ready),
      .out_item  (store_item)
   );

   // shading and result register
   tfps_shade u_shade (
      .clock           (clock),
      .reset           (reset),
      .palette_base    (cfg_ff.palette_base),
      .in_valid        (store_valid),
      .in_ready        (store_ready),
      .in_item         (store_item),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .out_pixel_value (rsp_pixel_value),
      .out_draw        (rsp_draw),
      .out_screen_row  (rsp_screen_row)
   );

`ifndef SYNTHESIS
   // nothing survives reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // pixels that are not drawn carry zero
   a_nodraw_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_draw |-> rsp_pixel_value == 8'd0)
      else $error("undrawn pixel with nonzero value");

   // a texel handed to the shade stage shows up as a result next cycle
   a_store_to_rsp : assert property (@(posedge clock) disable iff (reset)
      store_valid && store_ready |=> rsp_valid)
      else $error("texel item lost before the result register");

   // only load items write the store
   a_write_is_load : assert property (@(posedge clock) disable iff (reset)
      geom_valid && geom_item.wr_en |-> !geom_item.render)
      else $error("render item flagged as store write");
`endif

endmodule
